FILE: rtl/lirg_pkg.sv
// Shared types, constants and codes for the lockstep input reorder gate.
package lirg_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] IDLE_BUTTONS = 16'hFFFF;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_GATE    = 2'd1;
    localparam logic [1:0] OP_SEED    = 2'd2;

    localparam logic [2:0] ST_ADVANCED    = 3'd0;
    localparam logic [2:0] ST_FAST_FWD    = 3'd1;
    localparam logic [2:0] ST_SPECULATED  = 3'd2;
    localparam logic [2:0] ST_UNSYNCED    = 3'd3;
    localparam logic [2:0] ST_STALL_HARD  = 3'd4;
    localparam logic [2:0] ST_STORED      = 3'd5;
    localparam logic [2:0] ST_STORED_DROP = 3'd6;
    localparam logic [2:0] ST_SEEDED      = 3'd7;

    typedef struct packed {
        logic [31:0] frame;
        logic [15:0] buttons;
        logic [7:0]  left;
        logic [7:0]  right;
    } entry_t;

    typedef struct packed {
        logic        pop;
        logic        ins;
        entry_t      new_entry;
    } queue_ctl_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic        slot;
        logic [31:0] frame_number;
        logic [15:0] buttons;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
    } in_beat_t;

    typedef struct packed {
        logic        advance;
        logic [2:0]  status;
        logic [15:0] slot0_buttons;
        logic [7:0]  slot0_left;
        logic [7:0]  slot0_right;
        logic [15:0] slot1_buttons;
        logic [7:0]  slot1_left;
        logic [7:0]  slot1_right;
        logic [31:0] current_frame;
    } out_beat_t;

endpackage

FILE: rtl/lirg_cell.sv
// One queue cell: holds an entry, shifts toward head on pop, makes room on sorted insert.
module lirg_cell
    import lirg_pkg::*;
(
    input  logic       clk,
    input  queue_ctl_t ctl,
    input  logic       valid,
    input  logic       at_fill,
    input  entry_t     left_entry,
    input  logic       left_gt,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       gt
);

    entry_t entry_reg;
    entry_t entry_next;

    assign entry = entry_reg;
    assign gt    = valid && (entry_reg.frame > ctl.new_entry.frame);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.pop)
        begin
            entry_next = right_entry;
        end
        else if (ctl.ins)
        begin
            if (left_gt)
            begin
                entry_next = left_entry;
            end
            else if (gt || at_fill)
            begin
                entry_next = ctl.new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/lirg_queue.sv
// Frame-sorted queue for one slot: a row of cells plus the fill count.
module lirg_queue
    import lirg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  queue_ctl_t        ctl,
    output entry_t            head,
    output logic [FILL_W-1:0] fill
);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    entry_t            cell_entry [QUEUE_DEPTH];
    logic              cell_gt    [QUEUE_DEPTH];

    assign head = cell_entry[0];
    assign fill = fill_reg;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_g;

        if (i == 0)
        begin : g_first
            assign left_e = cell_entry[i];
            assign left_g = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_g = cell_gt[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_e = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        lirg_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .valid       (FILL_W'(i) < fill_reg),
            .at_fill     (FILL_W'(i) == fill_reg),
            .left_entry  (left_e),
            .left_gt     (left_g),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.pop && (fill_reg != '0))
        begin
            fill_next = fill_reg - 1'b1;
        end
        else if (ctl.ins)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: rtl/lockstep_input_reorder_gate_core.sv
// Top level: command sequencer, held inputs, frame counter and two sorted slot queues.
//
// Each slot queue is a row of QUEUE_DEPTH cells that shift together, so an enqueue
// is a sorted insert in S_INSERT after the issue in S_IDLE, with a drop of the
// head in S_MAKE_ROOM first when the queue is full. A seed is handled in S_IDLE. A
// gate request discards stale heads in S_DROP (both queues discard in parallel,
// one entry each per cycle) and then applies the queue heads in S_APPLY; an
// unsynced request without a seed returns from S_IDLE. Each result appears on
// result for exactly one cycle with done high, in the cycle after the last step
// of its beat; there is no backpressure, so the receiver must take it.
// The stall policy register may be written any time the block is idle.
module lockstep_input_reorder_gate_core
    import lirg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_beat_t  cmd,
    output logic      done,
    output out_beat_t result,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAKE_ROOM,
        S_INSERT,
        S_DROP,
        S_APPLY
    } state_t;

    state_t            state_reg,  state_next;
    in_beat_t          item_reg,   item_next;
    logic              drop_reg,   drop_next;
    logic [31:0]       lf_reg,     lf_next;
    logic              ready_reg,  ready_next;
    logic              synced_reg, synced_next;
    logic              policy_reg, policy_next;
    logic [15:0]       hbtn_reg  [2];
    logic [15:0]       hbtn_next [2];
    logic [7:0]        hl_reg    [2];
    logic [7:0]        hl_next   [2];
    logic [7:0]        hr_reg    [2];
    logic [7:0]        hr_next   [2];
    logic              done_reg,   done_next;
    out_beat_t         result_reg, result_next;

    queue_ctl_t        qctl  [2];
    entry_t            qhead [2];
    logic [FILL_W-1:0] qfill [2];
    logic              need_drop [2];
    logic              sat [2];
    logic              ahead [2];
    logic              ff;
    logic [31:0]       ff_frame;
    logic              emit;
    logic              emit_adv;
    logic [2:0]        emit_status;
    entry_t            item_entry;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign item_entry = '{frame:   item_reg.frame_number,
                          buttons: item_reg.buttons,
                          left:    item_reg.left_trigger,
                          right:   item_reg.right_trigger};

    for (genvar s = 0; s < 2; s++)
    begin : g_queue
        always_comb
        begin
            need_drop[s] = (qfill[s] != '0) && (qhead[s].frame < lf_reg);
            sat[s]       = (qfill[s] != '0);
            ahead[s]     = sat[s] && (qhead[s].frame > lf_reg);

            qctl[s].new_entry = item_entry;
            qctl[s].ins = (state_reg == S_INSERT) && (item_reg.slot == 1'(s));
            qctl[s].pop = ((state_reg == S_MAKE_ROOM) && (item_reg.slot == 1'(s)))
                       || ((state_reg == S_DROP) && need_drop[s])
                       || ((state_reg == S_APPLY) && sat[s]);
        end

        lirg_queue u_queue (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (qctl[s]),
            .head  (qhead[s]),
            .fill  (qfill[s])
        );
    end

    always_comb
    begin
        ff       = ahead[0] || ahead[1];
        ff_frame = lf_reg;
        if (ahead[0] && (qhead[0].frame > ff_frame))
        begin
            ff_frame = qhead[0].frame;
        end
        if (ahead[1] && (qhead[1].frame > ff_frame))
        begin
            ff_frame = qhead[1].frame;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        drop_next   = drop_reg;
        lf_next     = lf_reg;
        ready_next  = ready_reg;
        synced_next = synced_reg;
        policy_next = cfg_we ? cfg_wdata : policy_reg;
        hbtn_next   = hbtn_reg;
        hl_next     = hl_reg;
        hr_next     = hr_reg;
        emit        = 1'b0;
        emit_adv    = 1'b0;
        emit_status = ST_STORED;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = cmd;
                    drop_next = 1'b0;
                    case (cmd.operation)
                        OP_ENQUEUE:
                        begin
                            if (qfill[cmd.slot] == FILL_W'(QUEUE_DEPTH))
                            begin
                                state_next = S_MAKE_ROOM;
                            end
                            else
                            begin
                                state_next = S_INSERT;
                            end
                        end
                        OP_SEED:
                        begin
                            lf_next     = cmd.frame_number;
                            ready_next  = 1'b1;
                            emit        = 1'b1;
                            emit_status = ST_SEEDED;
                        end
                        OP_GATE:
                        begin
                            if (synced_reg || ready_reg)
                            begin
                                synced_next = 1'b1;
                                state_next  = S_DROP;
                            end
                            else
                            begin
                                emit        = 1'b1;
                                emit_status = ST_UNSYNCED;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MAKE_ROOM:
            begin
                drop_next  = 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                emit        = 1'b1;
                emit_status = drop_reg ? ST_STORED_DROP : ST_STORED;
                state_next  = S_IDLE;
            end
            S_DROP:
            begin
                if (!need_drop[0] && !need_drop[1])
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                for (int s = 0; s < 2; s++)
                begin
                    if (sat[s])
                    begin
                        hbtn_next[s] = qhead[s].buttons;
                        hl_next[s]   = qhead[s].left;
                        hr_next[s]   = qhead[s].right;
                    end
                end
                emit = 1'b1;
                if (sat[0] && sat[1])
                begin
                    emit_adv = 1'b1;
                    if (ff)
                    begin
                        lf_next     = ff_frame + 32'd1;
                        emit_status = ST_FAST_FWD;
                    end
                    else
                    begin
                        lf_next     = lf_reg + 32'd1;
                        emit_status = ST_ADVANCED;
                    end
                end
                else if (policy_reg)
                begin
                    emit_adv    = 1'b1;
                    lf_next     = lf_reg + 32'd1;
                    emit_status = ST_SPECULATED;
                end
                else
                begin
                    emit_status = ST_STALL_HARD;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        done_next   = emit;
        result_next = '{advance:       emit_adv,
                        status:        emit_status,
                        slot0_buttons: hbtn_next[0],
                        slot0_left:    hl_next[0],
                        slot0_right:   hr_next[0],
                        slot1_buttons: hbtn_next[1],
                        slot1_left:    hl_next[1],
                        slot1_right:   hr_next[1],
                        current_frame: lf_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            drop_reg   <= 1'b0;
            lf_reg     <= '0;
            ready_reg  <= 1'b0;
            synced_reg <= 1'b0;
            policy_reg <= 1'b0;
            hbtn_reg   <= '{IDLE_BUTTONS, IDLE_BUTTONS};
            hl_reg     <= '{8'd0, 8'd0};
            hr_reg     <= '{8'd0, 8'd0};
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            drop_reg   <= drop_next;
            lf_reg     <= lf_next;
            ready_reg  <= ready_next;
            synced_reg <= synced_next;
            policy_reg <= policy_next;
            hbtn_reg   <= hbtn_next;
            hl_reg     <= hl_next;
            hr_reg     <= hr_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

endmodule

FILE: tb/sv/tb_lockstep_input_reorder_gate_core.sv
// Testbench for the lockstep input reorder gate: directed and random beats vs. a predictor.
`timescale 1ns / 1ps

module tb_lockstep_input_reorder_gate_core;
    import lirg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTED    = 40;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class gate_tracker;
        entry_t      slot_q[2][$];
        logic [31:0] frame_ctr;
        bit          ready;
        bit          in_sync;
        logic [15:0] hold_btn[2];
        logic [7:0]  hold_l[2];
        logic [7:0]  hold_r[2];
        bit          policy;
        out_beat_t   pending_gate_results[$];
        int          errors;
        int          beats;
        int          results;
        int          status_seen[8];

        function new();
            frame_ctr = '0;
            ready     = 1'b0;
            in_sync   = 1'b0;
            policy    = 1'b0;
            for (int s = 0; s < 2; s++)
            begin
                hold_btn[s] = IDLE_BUTTONS;
                hold_l[s]   = '0;
                hold_r[s]   = '0;
            end
            errors  = 0;
            beats   = 0;
            results = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_policy(bit v);
            policy = v;
        endfunction

        function int pending();
            return pending_gate_results.size();
        endfunction

        function void push_outputs(bit adv, logic [2:0] st);
            out_beat_t o;
            o.advance       = adv;
            o.status        = st;
            o.slot0_buttons = hold_btn[0];
            o.slot0_left    = hold_l[0];
            o.slot0_right   = hold_r[0];
            o.slot1_buttons = hold_btn[1];
            o.slot1_left    = hold_l[1];
            o.slot1_right   = hold_r[1];
            o.current_frame = frame_ctr;
            pending_gate_results = {pending_gate_results, o};
            status_seen[st]++;
        endfunction

        function void drop_old(int s, logic [31:0] f);
            while (slot_q[s].size() > 0 && slot_q[s][0].frame < f)
                slot_q[s].delete(0);
        endfunction

        function void note_command(in_beat_t c);
            entry_t      e;
            entry_t      head;
            logic [2:0]  st;
            int          pos;
            int          s;
            logic [31:0] lf;
            logic [31:0] ff_frame;
            bit          ff;
            bit [1:0]    sat;
            beats++;
            case (c.operation)
                OP_ENQUEUE:
                begin
                    s = int'(c.slot);
                    e.frame   = c.frame_number;
                    e.buttons = c.buttons;
                    e.left    = c.left_trigger;
                    e.right   = c.right_trigger;
                    st = ST_STORED;
                    while (slot_q[s].size() >= QUEUE_DEPTH)
                    begin
                        slot_q[s].delete(0);
                        st = ST_STORED_DROP;
                    end
                    pos = slot_q[s].size();
                    while (pos > 0 && slot_q[s][pos-1].frame > e.frame)
                        pos--;
                    slot_q[s].insert(pos, e);
                    push_outputs(1'b0, st);
                end
                OP_SEED:
                begin
                    frame_ctr = c.frame_number;
                    ready     = 1'b1;
                    push_outputs(1'b0, ST_SEEDED);
                end
                OP_GATE:
                begin
                    if (!in_sync)
                    begin
                        if (!ready)
                        begin
                            push_outputs(1'b0, ST_UNSYNCED);
                            return;
                        end
                        drop_old(0, frame_ctr);
                        drop_old(1, frame_ctr);
                        in_sync = 1'b1;
                    end
                    lf       = frame_ctr;
                    ff_frame = lf;
                    ff       = 1'b0;
                    sat      = '0;
                    for (s = 0; s < 2; s++)
                    begin
                        drop_old(s, lf);
                        if (slot_q[s].size() == 0)
                            continue;
                        head = slot_q[s][0];
                        slot_q[s].delete(0);
                        if (head.frame > lf)
                        begin
                            ff = 1'b1;
                            if (head.frame > ff_frame)
                                ff_frame = head.frame;
                        end
                        hold_btn[s] = head.buttons;
                        hold_l[s]   = head.left;
                        hold_r[s]   = head.right;
                        sat[s]      = 1'b1;
                    end
                    if (sat == 2'b11)
                    begin
                        frame_ctr = ff ? ff_frame + 32'd1 : lf + 32'd1;
                        push_outputs(1'b1, ff ? ST_FAST_FWD : ST_ADVANCED);
                    end
                    else if (policy)
                    begin
                        frame_ctr = lf + 32'd1;
                        push_outputs(1'b1, ST_SPECULATED);
                    end
                    else
                    begin
                        push_outputs(1'b0, ST_STALL_HARD);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("%0t ERROR %s", $time, msg);
            errors++;
        endtask

        task cmp(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h want %0h", results, name, got, want));
        endtask

        task check_result(out_beat_t r);
            out_beat_t e;
            results++;
            if (pending_gate_results.size() == 0)
            begin
                report($sformatf("result %0d with nothing pending, status %0d", results,
                                 r.status));
                return;
            end
            e = pending_gate_results[0];
            pending_gate_results.delete(0);
            cmp("advance", 32'(r.advance), 32'(e.advance));
            cmp("status", 32'(r.status), 32'(e.status));
            cmp("slot0_buttons", 32'(r.slot0_buttons), 32'(e.slot0_buttons));
            cmp("slot0_left", 32'(r.slot0_left), 32'(e.slot0_left));
            cmp("slot0_right", 32'(r.slot0_right), 32'(e.slot0_right));
            cmp("slot1_buttons", 32'(r.slot1_buttons), 32'(e.slot1_buttons));
            cmp("slot1_left", 32'(r.slot1_left), 32'(e.slot1_left));
            cmp("slot1_right", 32'(r.slot1_right), 32'(e.slot1_right));
            cmp("current_frame", r.current_frame, e.current_frame);
        endtask
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    in_beat_t  cmd = '0;
    logic      done;
    out_beat_t result;
    logic      cfg_we = 1'b0;
    logic      cfg_wdata = 1'b0;

    gate_tracker sb;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;

    lockstep_input_reorder_gate_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lockstep_input_reorder_gate_core: mismatch");
            $finish;
        end
    end

    function automatic in_beat_t beat(logic [1:0] op, logic s, logic [31:0] f,
                                      logic [15:0] b, logic [7:0] l, logic [7:0] r);
        in_beat_t c;
        c.operation     = op;
        c.slot          = s;
        c.frame_number  = f;
        c.buttons       = b;
        c.left_trigger  = l;
        c.right_trigger = r;
        return c;
    endfunction

    function automatic in_beat_t rand_beat(logic [1:0] op, logic s, logic [31:0] f);
        return beat(op, s, f, 16'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // mostly on the current frame, some stale, some ahead, rare far away
    function automatic logic [31:0] near_frame(logic [31:0] lf);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 11)
            return lf;
        else if (pick < 14)
            return lf - 32'($urandom_range(1, 2));
        else if (pick < 16)
            return lf + 32'd1;
        else if (pick < 19)
            return lf + 32'($urandom_range(2, 6));
        else
            return $urandom;
    endfunction

    task automatic pace();
        if (gaps_on && burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
    endtask

    task automatic send(in_beat_t c);
        cmd   <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(c);
        pace();
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_policy(bit v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_policy(v);
    endtask

    // fill one queue past its depth, then seed ahead so the next gate drains it
    task automatic flood(int s, inout int sent);
        logic [31:0] lf;
        lf = sb.frame_ctr;
        repeat (QUEUE_DEPTH + 6)
        begin
            send(rand_beat(OP_ENQUEUE, 1'(s), lf + 32'($urandom_range(0, 40))));
            sent++;
        end
        send(rand_beat(OP_SEED, 1'($urandom), lf + 32'd100));
        send(rand_beat(OP_GATE, 1'($urandom), $urandom));
        sent += 2;
    endtask

    task automatic random_round(inout int sent);
        int          kind;
        int          first;
        int          s;
        logic [31:0] lf;
        kind  = $urandom_range(0, 99);
        lf    = sb.frame_ctr;
        first = $urandom_range(0, 1);
        if (kind < 62)
        begin
            for (int i = 0; i < 2; i++)
            begin
                s = first ^ i;
                if ($urandom_range(0, 99) < 88)
                begin
                    repeat (($urandom_range(0, 4) == 0) ? 2 : 1)
                    begin
                        send(rand_beat(OP_ENQUEUE, 1'(s), near_frame(lf)));
                        sent++;
                    end
                end
            end
            send(rand_beat(OP_GATE, 1'($urandom), $urandom));
            sent++;
        end
        else if (kind < 70)
        begin
            case ($urandom_range(0, 3))
                0: lf = $urandom;
                1: lf = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
                default: lf = lf + 32'($urandom_range(0, 3)) - 32'd1;
            endcase
            send(rand_beat(OP_SEED, 1'($urandom), lf));
            sent++;
        end
        else if (kind < 82)
        begin
            send(rand_beat(OP_GATE, 1'($urandom), $urandom));
            sent++;
        end
        else if (kind < 94)
        begin
            send(rand_beat(OP_ENQUEUE, 1'($urandom), $urandom));
            sent++;
        end
        else
        begin
            send(rand_beat(OP_UNUSED, 1'($urandom), $urandom));
        end
    endtask

    initial
    begin
        int sent;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_policy(1'b0);
        send(rand_beat(OP_GATE, 1'b0, 32'd0));
        send(beat(OP_ENQUEUE, 1'b0, 32'hFFFF_FFFF, 16'h0000, 8'hFF, 8'h00));
        send(beat(OP_ENQUEUE, 1'b1, 32'd0, 16'hFFFF, 8'h00, 8'hFF));
        send(rand_beat(OP_UNUSED, 1'b1, $urandom));
        send(rand_beat(OP_GATE, 1'b1, 32'hFFFF_FFFF));
        send(rand_beat(OP_SEED, 1'b0, 32'd10));
        send(beat(OP_ENQUEUE, 1'b0, 32'd4, 16'h1234, 8'h11, 8'h22));
        send(beat(OP_ENQUEUE, 1'b0, 32'd10, 16'hA5A5, 8'h33, 8'h44));
        send(beat(OP_ENQUEUE, 1'b0, 32'd10, 16'h5A5A, 8'h55, 8'h66));
        send(beat(OP_ENQUEUE, 1'b1, 32'd12, 16'hC3C3, 8'h77, 8'h88));
        // first sync drops stale heads, then fast-forwards past slot 1
        send(rand_beat(OP_GATE, 1'b0, $urandom));
        send(rand_beat(OP_GATE, 1'b0, $urandom));
        send(rand_beat(OP_GATE, 1'b1, $urandom));

        write_policy(1'b1);
        send(rand_beat(OP_GATE, 1'b0, $urandom));
        send(rand_beat(OP_SEED, 1'b1, 32'hFFFF_FFFE));
        send(rand_beat(OP_ENQUEUE, 1'b0, 32'hFFFF_FFFE));
        send(rand_beat(OP_ENQUEUE, 1'b1, 32'hFFFF_FFFE));
        send(rand_beat(OP_GATE, 1'b0, $urandom));
        send(rand_beat(OP_ENQUEUE, 1'b0, 32'hFFFF_FFFF));
        send(rand_beat(OP_ENQUEUE, 1'b1, 32'hFFFF_FFFF));
        send(rand_beat(OP_GATE, 1'b1, $urandom));
        send(rand_beat(OP_SEED, 1'b0, 32'd5));
        send(rand_beat(OP_ENQUEUE, 1'b0, 32'hFFFF_FFFF));
        send(rand_beat(OP_ENQUEUE, 1'b1, 32'd7));
        send(rand_beat(OP_GATE, 1'b0, $urandom));

        sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_policy(1'(ph % 2));
            gaps_on    = (ph != 2);
            burst_left = 0;
            if (ph < 2)
                flood(ph, sent);
            while (sent < 100 * (ph + 1))
                random_round(sent);
        end

        settle();
        $display("Covered %0d beats, %0d results, both stall policies, full queues, wrap.",
                 sb.beats, sb.results);
        $display("Status counts adv/ff/spec/unsync/hard/stored/drop/seed: %0d %0d %0d %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3]);
        $display("    %0d %0d %0d %0d",
                 sb.status_seen[4], sb.status_seen[5], sb.status_seen[6],
                 sb.status_seen[7]);
        if (sb.errors == 0)
            $display("lockstep_input_reorder_gate_core: match");
        else
            $display("lockstep_input_reorder_gate_core: mismatch");
        $finish;
    end

endmodule
